[src/slc_pkg.sv]
// shared types and defaults for the sorted list insert/search core
`default_nettype none

package slc_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REQ_INSERT,
    REQ_SEARCH,
    REQ_DUMP,
    REQ_UNUSED
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_FULL,
    ST_FOUND,
    ST_MISSING,
    ST_DUMPED
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occ;
    logic     tail;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/slc_cell.sv]
// one storage cell of the sorted chain
`default_nettype none

module slc_cell #(
  parameter int VALUE_WIDTH = slc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire slc_pkg::cell_ctl_t     ctl,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [VALUE_WIDTH-1:0] left_entry,
  input  wire logic                   left_lt,
  input  wire logic [VALUE_WIDTH-1:0] right_entry,
  input  wire logic [VALUE_WIDTH-1:0] head_entry,
  output logic      [VALUE_WIDTH-1:0] entry,
  output logic                        lt,
  output logic                        eq
);

  logic [VALUE_WIDTH-1:0] entry_next;

  assign lt = ctl.occ && ($signed(entry) < $signed(value));
  assign eq = ctl.occ && (entry == value);

  always_comb begin
    case (ctl.op)
      slc_pkg::CELL_INSERT: begin
        // keep smaller entries, the first cell past them takes the new value, later cells take their left neighbour's
        if (lt) begin
          entry_next = entry;
        end else if (left_lt) begin
          entry_next = value;
        end else begin
          entry_next = left_entry;
        end
      end
      slc_pkg::CELL_ROTATE: begin
        entry_next = ctl.tail ? head_entry : right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

[src/sorted_list_insert_search_core.sv]
// sorted list core: control and the chain of storage cells
//
// Keeps up to CAPACITY signed values in ascending order, one per cell.
// Command channel: start with req_type and item_value is taken when
// busy is low. req_type 0 inserts (in front of equal entries), 1 searches,
// 2 dumps all entries in ascending order, 3 is ignored.
// Result channel: done marks one result for exactly one cycle on status,
// result_value, last and entry_count; the receiver cannot stall it.
// Insert and search: one result, in the cycle after the command transfer;
// busy stays low, so a new command can follow every cycle. All cells
// compare against the command value in parallel, so the list length
// does not change this.
// Dump of n entries: busy while the chain rotates its occupied cells
// one position per cycle; results come out one per cycle, the first once
// state has entered DUMP and done is registered, last marked on the final one.
// An empty dump gives no result and does not raise busy.
// Reset clears the entry count and the control state; cell contents are
// left as they are and are never read before being written.
`default_nettype none

module sorted_list_insert_search_core #(
  parameter int CAPACITY    = slc_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = slc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  req_type,
  input  wire logic signed [31:0] item_value,
  output logic                    done,
  output logic             [2:0]  status,
  output logic signed      [31:0] result_value,
  output logic                    last,
  output logic             [5:0]  entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    IDLE,
    DUMP
  } state_t;

  state_t  state;
  logic [CW-1:0] count;
  logic [CW-1:0] remain;

  logic [63:0]            item_ext;
  logic [VALUE_WIDTH-1:0] value;
  logic [63:0]            value_ext;
  logic [63:0]            head_ext;

  logic                   accept;
  logic                   full;
  logic                   hit;
  slc_pkg::cell_op_t      op;

  logic [VALUE_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]    lt_vec;
  logic [CAPACITY-1:0]    eq_vec;

  assign item_ext  = {32'd0, item_value};
  assign value     = item_ext[VALUE_WIDTH-1:0];
  assign value_ext = 64'(value);
  assign head_ext  = 64'(entries[0]);

  assign busy   = (state == DUMP);
  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign hit    = |eq_vec;

  always_comb begin
    if (state == DUMP) begin
      op = slc_pkg::CELL_ROTATE;
    end else if (accept && req_type == slc_pkg::REQ_INSERT && !full) begin
      op = slc_pkg::CELL_INSERT;
    end else begin
      op = slc_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slc_pkg::cell_ctl_t     ctl;
    logic [VALUE_WIDTH-1:0] left_entry;
    logic                   left_lt;
    logic [VALUE_WIDTH-1:0] right_entry;

    assign ctl.op   = op;
    assign ctl.occ  = (CW'(i) < count);
    assign ctl.tail = (count == CW'(i + 1));

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_inner
      assign left_entry = entries[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    slc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (value),
      .left_entry (left_entry),
      .left_lt    (left_lt),
      .right_entry(right_entry),
      .head_entry (entries[0]),
      .entry      (entries[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      count  <= '0;
      remain <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            case (req_type)
              slc_pkg::REQ_INSERT: begin
                done         <= 1'b1;
                last         <= 1'b1;
                result_value <= value_ext[31:0];
                if (full) begin
                  status      <= slc_pkg::ST_FULL;
                  entry_count <= 6'(count);
                end else begin
                  status      <= slc_pkg::ST_INSERTED;
                  count       <= count + 1'b1;
                  entry_count <= 6'(count + 1'b1);
                end
              end
              slc_pkg::REQ_SEARCH: begin
                done         <= 1'b1;
                last         <= 1'b1;
                result_value <= value_ext[31:0];
                status       <= hit ? slc_pkg::ST_FOUND : slc_pkg::ST_MISSING;
                entry_count  <= 6'(count);
              end
              slc_pkg::REQ_DUMP: begin
                if (count != '0) begin
                  state  <= DUMP;
                  remain <= count;
                end
              end
              default: begin
              end
            endcase
          end
        end
        DUMP: begin
          // head cell goes out while the occupied cells rotate by one
          done         <= 1'b1;
          status       <= slc_pkg::ST_DUMPED;
          result_value <= head_ext[31:0];
          entry_count  <= 6'(count);
          last         <= (remain == CW'(1));
          remain       <= remain - 1'b1;
          if (remain == CW'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
